// ===== src/mdm_pkg.sv =====
package mdm_pkg;

  localparam int WHEELS      = 4;
  localparam int AXIS_W      = 8;
  localparam int DRIVE_W     = 11;
  localparam int MIX_W       = 10;
  localparam int MAG_W       = 9;
  localparam int SCALE_W     = 10;
  localparam int PROD_W      = MAG_W + SCALE_W;
  localparam int QUOT_W      = 10;
  localparam int DIV_STEPS   = QUOT_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int WHEEL_W     = $clog2(WHEELS);
  localparam int CFG_DATA_W  = 10;
  localparam int CFG_IDX_W   = 2;

  localparam logic signed [MIX_W-1:0] AXIS_CENTRE = 10'sd128;
  localparam logic [MAG_W-1:0]        NORM_FLOOR  = 9'd128;

  localparam logic [7:0]         DEADBAND_RST   = 8'd15;
  localparam logic [9:0]         RAMP_STEP_RST  = 10'd10;
  localparam logic [SCALE_W-1:0] FULL_SCALE_RST = 10'd100;
  localparam logic [WHEELS-1:0]  POLARITY_RST   = 4'd9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADBAND   = 2'd0,
    REG_RAMP_STEP  = 2'd1,
    REG_FULL_SCALE = 2'd2,
    REG_POLARITY   = 2'd3
  } mdm_reg_t;

  typedef struct packed {
    logic               load_in;
    logic               mix_en;
    logic               peak_en;
    logic               mul_en;
    logic               div_step;
    logic               ramp_en;
    logic               out_load;
    logic [WHEEL_W-1:0] wheel;
  } mdm_cmd_t;

  typedef struct packed {
    logic link;
  } mdm_status_t;

endpackage

// ===== src/mdm_ctrl.sv =====
module mdm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  mdm_pkg::mdm_status_t status,
  output mdm_pkg::mdm_cmd_t   cmd
);
  import mdm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MIX,
    S_PEAK,
    S_MUL,
    S_DIV,
    S_RAMP,
    S_DONE
  } state_t;

  state_t               state;
  logic [WHEEL_W-1:0]   wheel;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.wheel    = wheel;
    cmd.load_in  = (state == S_IDLE) && in_valid;
    cmd.mix_en   = (state == S_MIX);
    cmd.peak_en  = (state == S_PEAK);
    cmd.mul_en   = (state == S_MUL);
    cmd.div_step = (state == S_DIV);
    cmd.ramp_en  = (state == S_RAMP);
    cmd.out_load = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      wheel     <= '0;
      div_cnt   <= '0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MIX;
          end
        end
        S_MIX: begin
          wheel <= '0;
          state <= status.link ? S_PEAK : S_DONE;
        end
        S_PEAK: begin
          state <= S_MUL;
        end
        S_MUL: begin
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= S_RAMP;
          end else begin
            div_cnt <= div_cnt + 1'b1;
          end
        end
        S_RAMP: begin
          if (wheel == WHEEL_W'(WHEELS - 1)) begin
            state <= S_DONE;
          end else begin
            wheel <= wheel + 1'b1;
            state <= S_MUL;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/mdm_dp.sv =====
module mdm_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  mdm_pkg::mdm_cmd_t                      cmd,
  output mdm_pkg::mdm_status_t                   status,
  input  logic                                   cfg_we,
  input  logic [mdm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [mdm_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic [mdm_pkg::AXIS_W-1:0]             left_x,
  input  logic [mdm_pkg::AXIS_W-1:0]             left_y,
  input  logic [mdm_pkg::AXIS_W-1:0]             right_x,
  input  logic                                   connected,
  output logic signed [mdm_pkg::DRIVE_W-1:0]     drive_front_left,
  output logic signed [mdm_pkg::DRIVE_W-1:0]     drive_rear_left,
  output logic signed [mdm_pkg::DRIVE_W-1:0]     drive_front_right,
  output logic signed [mdm_pkg::DRIVE_W-1:0]     drive_rear_right,
  output logic                                   stop_all
);
  import mdm_pkg::*;

  // configuration
  logic [7:0]         deadband;
  logic [9:0]         ramp_step;
  logic [SCALE_W-1:0] full_scale;
  logic [WHEELS-1:0]  polarity_mask;

  // captured sample
  logic [AXIS_W-1:0] lx, ly, rx;
  logic              link;

  logic signed [MIX_W-1:0]   mix [WHEELS];
  logic [MAG_W-1:0]          peak;
  logic                      neg;
  logic [MAG_W-1:0]          rem;
  logic [QUOT_W-1:0]         quot;
  logic signed [DRIVE_W-1:0] wheel_command [WHEELS];

  logic signed [MIX_W-1:0]   fwd, rot, str;
  logic [MAG_W-1:0]          peak_c;
  logic [MAG_W-1:0]          mag_w;
  logic [PROD_W-1:0]         prod;
  logic [MAG_W:0]            trial;
  logic                      q_bit;
  logic signed [DRIVE_W:0]   target, cur, up, dn, c_next;
  logic signed [DRIVE_W-1:0] drv [WHEELS];

  function automatic logic signed [MIX_W-1:0] dead(input logic signed [MIX_W-1:0] v,
                                                   input logic [7:0] db);
    logic [MIX_W-1:0] a;
    a = v[MIX_W-1] ? MIX_W'(-v) : v;
    return (a < MIX_W'(db)) ? '0 : v;
  endfunction

  function automatic logic [MAG_W-1:0] mag(input logic signed [MIX_W-1:0] v);
    logic [MIX_W-1:0] n;
    n = MIX_W'(-v);
    return v[MIX_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

  assign status.link = link;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband      <= DEADBAND_RST;
      ramp_step     <= RAMP_STEP_RST;
      full_scale    <= FULL_SCALE_RST;
      polarity_mask <= POLARITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEADBAND:   deadband      <= cfg_data[7:0];
        REG_RAMP_STEP:  ramp_step     <= cfg_data[9:0];
        REG_FULL_SCALE: full_scale    <= cfg_data[SCALE_W-1:0];
        REG_POLARITY:   polarity_mask <= cfg_data[WHEELS-1:0];
      endcase
    end
  end

  // axis centring and deadband
  always_comb begin
    fwd = dead(AXIS_CENTRE - $signed({2'b00, ly}), deadband);
    rot = dead($signed({2'b00, lx}) - AXIS_CENTRE, deadband);
    str = dead(AXIS_CENTRE - $signed({2'b00, rx}), deadband);
  end

  always_comb begin
    peak_c = NORM_FLOOR;
    for (int i = 0; i < WHEELS; i++) begin
      if (mag(mix[i]) > peak_c) begin
        peak_c = mag(mix[i]);
      end
    end
  end

  assign mag_w = mag(mix[cmd.wheel]);
  assign prod  = PROD_W'(mag_w) * PROD_W'(full_scale);

  // one restoring step per cycle
  assign trial = {rem, quot[QUOT_W-1]} - {1'b0, peak};
  assign q_bit = ({rem, quot[QUOT_W-1]} >= {1'b0, peak});

  always_comb begin
    target = neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
    cur    = {wheel_command[cmd.wheel][DRIVE_W-1], wheel_command[cmd.wheel]};
    up     = cur + $signed({2'b00, ramp_step});
    dn     = cur - $signed({2'b00, ramp_step});
    if (cur < target) begin
      c_next = (up < target) ? up : target;
    end else begin
      c_next = (dn > target) ? dn : target;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      lx   <= left_x;
      ly   <= left_y;
      rx   <= right_x;
      link <= connected;
    end
    if (cmd.mix_en) begin
      mix[0] <= fwd + str + rot;
      mix[1] <= fwd - str + rot;
      mix[2] <= fwd - str - rot;
      mix[3] <= fwd + str - rot;
    end
    if (cmd.peak_en) begin
      peak <= peak_c;
    end
    if (cmd.mul_en) begin
      neg  <= mix[cmd.wheel][MIX_W-1];
      rem  <= prod[PROD_W-1:QUOT_W];
      quot <= prod[QUOT_W-1:0];
    end else if (cmd.div_step) begin
      rem  <= q_bit ? trial[MAG_W-1:0] : {rem[MAG_W-2:0], quot[QUOT_W-1]};
      quot <= {quot[QUOT_W-2:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WHEELS; i++) begin
        wheel_command[i] <= '0;
      end
    end else if (cmd.ramp_en) begin
      wheel_command[cmd.wheel] <= c_next[DRIVE_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < WHEELS; i++) begin
      drv[i] = polarity_mask[i] ? -wheel_command[i] : wheel_command[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      drive_front_left  <= link ? drv[0] : '0;
      drive_rear_left   <= link ? drv[1] : '0;
      drive_front_right <= link ? drv[2] : '0;
      drive_rear_right  <= link ? drv[3] : '0;
      stop_all          <= !link;
    end
  end

endmodule

// ===== src/mecanum_drive_mixer.sv =====
// One item is in work at a time: a new input is taken only once the previous
// result has been loaded into the output register. With the link up, the
// shared 10-step restoring divider serves the four wheels in turn; with the
// link lost, the divider and the ramps are skipped.
// Reset: configuration returns to its defaults (deadband 15, ramp step 10,
// full scale 100, polarity 9), held wheel commands clear, no result pending.
module mecanum_drive_mixer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [mdm_pkg::AXIS_W-1:0]           left_x,
  input  logic [mdm_pkg::AXIS_W-1:0]           left_y,
  input  logic [mdm_pkg::AXIS_W-1:0]           right_x,
  input  logic                                 connected,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mdm_pkg::DRIVE_W-1:0]   drive_front_left,
  output logic signed [mdm_pkg::DRIVE_W-1:0]   drive_rear_left,
  output logic signed [mdm_pkg::DRIVE_W-1:0]   drive_front_right,
  output logic signed [mdm_pkg::DRIVE_W-1:0]   drive_rear_right,
  output logic                                 stop_all,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mdm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mdm_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import mdm_pkg::*;

  mdm_cmd_t    cmd;
  mdm_status_t status;

  // Configuration writes are always accepted, so the port never stalls.
  assign cfg_ready = 1'b1;

  // Controller: sequences capture, mix and, with the link up, peak search,
  // then per wheel a multiply, ten divide steps and a ramp update, and finally
  // loads the output register once the previous result has been transferred.
  mdm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: configuration registers, sample capture, mixing, the shared
  // divider, the held wheel commands and the output register. A lost link
  // skips straight to the output load and leaves the wheel commands alone.
  mdm_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .left_x            (left_x),
    .left_y            (left_y),
    .right_x           (right_x),
    .connected         (connected),
    .drive_front_left  (drive_front_left),
    .drive_rear_left   (drive_rear_left),
    .drive_front_right (drive_front_right),
    .drive_rear_right  (drive_rear_right),
    .stop_all          (stop_all)
  );

endmodule

// ===== tb/mdm_drive_checker.sv =====
module mdm_drive_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [mdm_pkg::AXIS_W-1:0]          left_x,
  input  logic [mdm_pkg::AXIS_W-1:0]          left_y,
  input  logic [mdm_pkg::AXIS_W-1:0]          right_x,
  input  logic                                connected,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [mdm_pkg::DRIVE_W-1:0]  drive_front_left,
  input  logic signed [mdm_pkg::DRIVE_W-1:0]  drive_rear_left,
  input  logic signed [mdm_pkg::DRIVE_W-1:0]  drive_front_right,
  input  logic signed [mdm_pkg::DRIVE_W-1:0]  drive_rear_right,
  input  logic                                stop_all,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [mdm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mdm_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                  mismatches,
  output int                                  pending,
  output int                                  drive_sets_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import mdm_pkg::*;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] front_left;
    logic signed [DRIVE_W-1:0] rear_left;
    logic signed [DRIVE_W-1:0] front_right;
    logic signed [DRIVE_W-1:0] rear_right;
    logic                      stop;
  } drive_set_t;

  logic [7:0]                deadband;
  logic [9:0]                ramp_step;
  logic [SCALE_W-1:0]        full_scale;
  logic [WHEELS-1:0]         polarity;
  logic signed [DRIVE_W-1:0] wheel_cmd [WHEELS];
  drive_set_t                drive_due [$];

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int apply_deadband(int v);
    return (magnitude(v) < int'(deadband)) ? 0 : v;
  endfunction

  // Mix one stick sample into the four wheel drives and, if linked, advance the held commands.
  function automatic drive_set_t mix_wheels(logic [AXIS_W-1:0] lx, logic [AXIS_W-1:0] ly,
                                            logic [AXIS_W-1:0] rx, logic link);
    drive_set_t                res;
    int                        fwd, strafe, rot, peak, target, cmd, step;
    int                        mix [WHEELS];
    logic signed [DRIVE_W-1:0] drv [WHEELS];
    res = '0;
    if (!link) begin
      res.stop = 1'b1;
      return res;
    end
    fwd    = apply_deadband(int'(AXIS_CENTRE) - int'(ly));
    rot    = apply_deadband(int'(lx) - int'(AXIS_CENTRE));
    strafe = apply_deadband(int'(AXIS_CENTRE) - int'(rx));
    mix[0] = fwd + strafe + rot;
    mix[1] = fwd - strafe + rot;
    mix[2] = fwd - strafe - rot;
    mix[3] = fwd + strafe - rot;
    peak = int'(NORM_FLOOR);
    for (int i = 0; i < WHEELS; i++)
      if (magnitude(mix[i]) > peak) peak = magnitude(mix[i]);
    step = int'(ramp_step);
    for (int i = 0; i < WHEELS; i++) begin
      target = (mix[i] * int'(full_scale)) / peak;
      cmd = int'(wheel_cmd[i]);
      if (cmd < target)
        cmd = (cmd + step < target) ? cmd + step : target;
      else
        cmd = (cmd - step > target) ? cmd - step : target;
      wheel_cmd[i] = cmd[DRIVE_W-1:0];
      drv[i] = polarity[i] ? -wheel_cmd[i] : wheel_cmd[i];
    end
    res.front_left  = drv[0];
    res.rear_left   = drv[1];
    res.front_right = drv[2];
    res.rear_right  = drv[3];
    return res;
  endfunction

  always @(posedge clk) begin
    drive_set_t want;
    if (rst) begin
      deadband   = DEADBAND_RST;
      ramp_step  = RAMP_STEP_RST;
      full_scale = FULL_SCALE_RST;
      polarity   = POLARITY_RST;
      for (int i = 0; i < WHEELS; i++) wheel_cmd[i] = '0;
      drive_due.delete();
      mismatches = 0;
      drive_sets_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (mdm_reg_t'(cfg_index))
          REG_DEADBAND:   deadband   = cfg_data[7:0];
          REG_RAMP_STEP:  ramp_step  = cfg_data[9:0];
          REG_FULL_SCALE: full_scale = cfg_data[SCALE_W-1:0];
          REG_POLARITY:   polarity   = cfg_data[WHEELS-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (drive_due.size() == 0) begin
          $error("drive set transferred with nothing expected");
          mismatches++;
        end else begin
          want = drive_due.pop_front();
          drive_sets_checked++;
          if (drive_front_left !== want.front_left) begin
            $error("drive_front_left: expected %0d, got %0d", want.front_left,
                   drive_front_left);
            mismatches++;
          end
          if (drive_rear_left !== want.rear_left) begin
            $error("drive_rear_left: expected %0d, got %0d", want.rear_left, drive_rear_left);
            mismatches++;
          end
          if (drive_front_right !== want.front_right) begin
            $error("drive_front_right: expected %0d, got %0d", want.front_right,
                   drive_front_right);
            mismatches++;
          end
          if (drive_rear_right !== want.rear_right) begin
            $error("drive_rear_right: expected %0d, got %0d", want.rear_right,
                   drive_rear_right);
            mismatches++;
          end
          if (stop_all !== want.stop) begin
            $error("stop_all: expected %0d, got %0d", want.stop, stop_all);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        drive_due.push_back(mix_wheels(left_x, left_y, right_x, connected));
    end
    pending = drive_due.size();
  end

endmodule

// ===== tb/tb_mecanum_drive_mixer.sv =====
module tb_mecanum_drive_mixer;
  timeunit 1ns;
  timeprecision 1ps;
  import mdm_pkg::*;

  // Generous ceiling for ~500 samples, worst case.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Long receiver hold-off, enough for the block to fill and refuse input.
  localparam int HOLD_CYCLES = 600;
  // Tail after the last drive set, a little beyond the latency of one sample.
  localparam int TAIL_CYCLES = 64;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 60;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [AXIS_W-1:0]         left_x = '0;
  logic [AXIS_W-1:0]         left_y = '0;
  logic [AXIS_W-1:0]         right_x = '0;
  logic                      connected = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [DRIVE_W-1:0] drive_front_left;
  logic signed [DRIVE_W-1:0] drive_rear_left;
  logic signed [DRIVE_W-1:0] drive_front_right;
  logic signed [DRIVE_W-1:0] drive_rear_right;
  logic                      stop_all;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  mdm_reg_t                  cfg_index = REG_DEADBAND;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  int mismatches;
  int pending;
  int drive_sets_checked;

  // Stimulus bookkeeping, shared with the receiver process.
  int  cycle_count = 0;
  int  samples_sent = 0;
  int  samples_lost = 0;
  int  reg_writes = 0;
  int  cur_deadband = int'(DEADBAND_RST);
  bit  idle_on = 1'b1;
  int  hold_asked = 0;
  int  hold_served = 0;

  always #10 clk = ~clk;

  mecanum_drive_mixer dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .left_x            (left_x),
    .left_y            (left_y),
    .right_x           (right_x),
    .connected         (connected),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .drive_front_left  (drive_front_left),
    .drive_rear_left   (drive_rear_left),
    .drive_front_right (drive_front_right),
    .drive_rear_right  (drive_rear_right),
    .stop_all          (stop_all),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  mdm_drive_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .left_x             (left_x),
    .left_y             (left_y),
    .right_x            (right_x),
    .connected          (connected),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .drive_front_left   (drive_front_left),
    .drive_rear_left    (drive_rear_left),
    .drive_front_right  (drive_front_right),
    .drive_rear_right   (drive_rear_right),
    .stop_all           (stop_all),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatches         (mismatches),
    .pending            (pending),
    .drive_sets_checked (drive_sets_checked)
  );

  // Watchdog: abandon the run if the block wedges somewhere.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Gap length for either side: mostly none, sometimes short, rarely long.
  // Phases with idling switched off run flat out.
  function automatic int idle_gap();
    int roll;
    if (!idle_on) return 0;
    roll = int'($urandom_range(0, 99));
    if (roll < 60) return 0;
    if (roll < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 60));
  endfunction

  // Stick position: extremes, centre, either side of the deadband edge, or anywhere.
  function automatic logic [AXIS_W-1:0] pick_axis();
    int v;
    case ($urandom_range(0, 7))
      0:       v = 0;
      1:       v = 255;
      2:       v = int'(AXIS_CENTRE);
      3:       v = int'(AXIS_CENTRE) + cur_deadband - int'($urandom_range(0, 1));
      4:       v = int'(AXIS_CENTRE) - cur_deadband + int'($urandom_range(0, 1));
      default: v = int'($urandom_range(0, 255));
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[AXIS_W-1:0];
  endfunction

  // Small wobble around a held stick position, saturating at the ends.
  function automatic logic [AXIS_W-1:0] nudge(logic [AXIS_W-1:0] v);
    case ($urandom_range(0, 3))
      0:       return (v == 8'd255) ? v : v + 8'd1;
      1:       return (v == 8'd0) ? v : v - 8'd1;
      default: return v;
    endcase
  endfunction

  // Offer one sample from a falling edge and hold it until the transfer.
  // Valid stays high on return unless a gap follows, so back-to-back samples
  // never see valid dropped and raised in the same step.
  task automatic offer_sample(input logic [AXIS_W-1:0] lx, input logic [AXIS_W-1:0] ly,
                              input logic [AXIS_W-1:0] rx, input logic link);
    int gap;
    left_x    = lx;
    left_y    = ly;
    right_x   = rx;
    connected = link;
    in_valid  = 1'b1;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
    if (!link) samples_lost++;
    @(negedge clk);
    gap = idle_gap();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drop the input and wait for every outstanding drive set to come back.
  task automatic drain_block();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input mdm_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Write all four registers; only call with the block drained.
  task automatic apply_setting(input logic [CFG_DATA_W-1:0] db,
                               input logic [CFG_DATA_W-1:0] ramp,
                               input logic [CFG_DATA_W-1:0] scale,
                               input logic [CFG_DATA_W-1:0] pol);
    write_reg(REG_DEADBAND, db);
    write_reg(REG_RAMP_STEP, ramp);
    write_reg(REG_FULL_SCALE, scale);
    write_reg(REG_POLARITY, pol);
    cur_deadband = int'(db[7:0]);
  endtask

  // Hand-picked samples under the reset configuration.
  task automatic run_directed();
    offer_sample(8'd128, 8'd128, 8'd128, 1'b1);  // centred sticks
    offer_sample(8'd255, 8'd128, 8'd128, 1'b1);  // full rotate one way
    offer_sample(8'd0,   8'd128, 8'd128, 1'b1);  // and the other
    offer_sample(8'd128, 8'd0,   8'd128, 1'b1);  // full forward
    offer_sample(8'd128, 8'd255, 8'd128, 1'b1);  // full reverse
    offer_sample(8'd128, 8'd128, 8'd0,   1'b1);  // full strafe
    offer_sample(8'd128, 8'd128, 8'd255, 1'b1);
    offer_sample(8'd0,   8'd0,   8'd0,   1'b1);  // every axis at its floor
    offer_sample(8'd255, 8'd255, 8'd255, 1'b1);  // every axis at its ceiling
    offer_sample(8'd255, 8'd0,   8'd0,   1'b1);  // combined demand beyond the floor
    offer_sample(8'd0,   8'd255, 8'd255, 1'b1);
    offer_sample(8'd142, 8'd114, 8'd142, 1'b1);  // just inside the deadband
    offer_sample(8'd143, 8'd113, 8'd113, 1'b1);  // right on the deadband edge
    offer_sample(8'd255, 8'd0,   8'd0,   1'b0);  // link lost: stop, commands kept
    offer_sample(8'd255, 8'd0,   8'd0,   1'b1);  // link back: ramp resumes
    repeat (3) offer_sample(8'd128, 8'd0, 8'd128, 1'b1);
    offer_sample(8'd0,   8'd255, 8'd255, 1'b0);
    offer_sample(8'd170, 8'd90,  8'd60,  1'b1);
    offer_sample(8'd85,  8'd170, 8'd200, 1'b1);
  endtask

  // Mostly held stick positions with a little wobble so the ramps settle,
  // with bursts of lost link and the odd unrelated sample mixed in.
  task automatic run_phase(input int count);
    int                done;
    int                burst;
    logic [AXIS_W-1:0] lx, ly, rx;
    done = 0;
    while (done < count) begin
      case ($urandom_range(0, 9))
        0: begin
          burst = int'($urandom_range(1, 3));
          repeat (burst)
            offer_sample(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        end
        1: begin
          burst = 1;
          offer_sample(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
        end
        default: begin
          burst = int'($urandom_range(1, 8));
          lx = pick_axis();
          ly = pick_axis();
          rx = pick_axis();
          repeat (burst) offer_sample(nudge(lx), nudge(ly), nudge(rx), 1'b1);
        end
      endcase
      done += burst;
    end
  endtask

  // Receiver: random stalls, plus a long hold-off whenever stimulus asks.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_served != hold_asked) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_served++;
      end else begin
        gap = idle_gap();
        if (gap != 0) begin
          out_ready = 1'b0;
          repeat (gap) @(negedge clk);
        end
        out_ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    repeat (4) @(negedge clk);
    rst = 1'b0;

    run_directed();

    for (int ph = 1; ph <= PHASES; ph++) begin
      drain_block();
      // Run some phases flat out on both sides.
      idle_on = (ph != 1 && ph != 5);
      case (ph)
        // Deadband off, fastest ramp, full scale at its ceiling, no inversion;
        // upper data bits are set on the narrow registers and must be dropped.
        1: apply_setting(10'h300, 10'd1023, 10'd1023, 10'h0F0);
        // Deadband swallows every axis, crawling ramp, tiny scale, all inverted.
        2: apply_setting(10'h0FF, 10'd1, 10'd1, 10'h00F);
        // Ramp of zero freezes the commands; full scale of zero kills targets.
        3: apply_setting(10'd128, 10'd0, 10'd0, 10'h006);
        // Back to defaults, and starve the output side for a long stretch.
        4: begin
          apply_setting(10'(DEADBAND_RST), 10'(RAMP_STEP_RST), 10'(FULL_SCALE_RST),
                        10'(POLARITY_RST));
          hold_asked++;
        end
        default: apply_setting({2'($urandom), 8'($urandom_range(0, 40))},
                               10'($urandom_range(1, 300)),
                               10'($urandom_range(1, 1023)),
                               10'($urandom));
      endcase
      run_phase(PHASE_ITEMS);
    end

    drain_block();
    // Hold a little longer to catch any stray drive set.
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d joystick samples (%0d with the link lost) over %0d register writes",
             samples_sent, samples_lost, reg_writes);
    $display("Checked %0d drive sets, %0d field mismatches", drive_sets_checked, mismatches);
    if (mismatches == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
src/mdm_pkg.sv
src/mdm_ctrl.sv
src/mdm_dp.sv
src/mecanum_drive_mixer.sv
tb/mdm_drive_checker.sv
tb/tb_mecanum_drive_mixer.sv
